// ----- hdl/hmmd_pkg.sv -----
// Shared types and constants of the history min/max downsampler.
package hmmd_pkg;

  localparam int unsigned LimitW     = 11;
  localparam int unsigned TimeW      = 48;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned MaxPtsW    = 7;
  localparam int unsigned OpW        = 2;
  localparam logic [LimitW-1:0] LimitReset = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_SNAP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SNAP,
    ST_RD,
    ST_DAT,
    ST_DIV,
    ST_C3,
    ST_BEMIT1,
    ST_BEMIT2
  } state_e;

  typedef enum logic [2:0] {
    PH_ALL,
    PH_LASTPT,
    PH_FIRST,
    PH_SCAN3,
    PH_SCANB,
    PH_LAST3
  } phase_e;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_PUSH,
    SRC_RD,
    SRC_MIN,
    SRC_MAX
  } src_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_ONE,
    IDX_INC,
    IDX_LAST
  } idx_op_e;

  typedef struct packed {
    logic    accept;
    logic    do_push;
    logic    do_clear;
    logic    rd_en;
    idx_op_e idx_op;
    logic    emit;
    src_e    src;
    logic    last;
    logic    save_first;
    logic    scan_init;
    logic    scan_upd;
    logic    div_start;
    logic    bkt_init;
    logic    bkt_next;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic lim_zero;
    logic fits;
    logic lim_one;
    logic lim_two;
    logic lim_three;
    logic out_free;
    logic idx_is_last;
    logic idx_is_nm2;
    logic idx_at_hi;
    logic div_done;
    logic bkt_last;
    logic mn_eq_mx;
    logic mn_lt_mx;
    logic pick_min;
  } sts_t;

endpackage

// ----- hdl/history_minmax_downsampler.sv -----
// Top level of the history min/max downsampler: controller plus datapath.
// Push, clear and unknown ops: the result beat is loaded from EXEC once the output reg is free.
// Snapshots read history entries one at a time through one memory read port, and run a
// restoring divider when min/max buckets are used.
// A new input beat is taken once the previous item has loaded its last beat into the output reg.
// Reset is asynchronous and clears control state; the history memory has no clearing pass.
module history_minmax_downsampler #(
  parameter int unsigned HISTORY_DEPTH   = 1024,
  parameter int unsigned MAX_PLOT_POINTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hmmd_pkg::LimitW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hmmd_pkg::OpW-1:0]            operation_i,
  input  logic [hmmd_pkg::TimeW-1:0]          sample_time_us_i,
  input  logic signed [hmmd_pkg::ValueW-1:0]  sample_value_i,
  input  logic [hmmd_pkg::MaxPtsW-1:0]        max_points_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic                                has_point_o,
  output logic [hmmd_pkg::TimeW-1:0]          point_time_us_o,
  output logic signed [hmmd_pkg::ValueW-1:0]  point_value_o,
  output logic                                last_o
);
  import hmmd_pkg::*;

  // The controller sequences every item; the datapath owns all storage.
  cmd_t cmd;
  sts_t sts;

  hmmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_e'(operation_i)),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Results leave through a registered output beat, so the controller
  // stalls on the output only when a new beat must be loaded while the old one waits.
  hmmd_datapath #(
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .MAX_PLOT_POINTS (MAX_PLOT_POINTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_time_us_i (sample_time_us_i),
    .sample_value_i   (sample_value_i),
    .max_points_i     (max_points_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .accepted_o       (accepted_o),
    .has_point_o      (has_point_o),
    .point_time_us_o  (point_time_us_o),
    .point_value_o    (point_value_o),
    .last_o           (last_o)
  );

endmodule

// ----- hdl/hmmd_ctrl.sv -----
// Controller state machine of the history min/max downsampler.
module hmmd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hmmd_pkg::op_e  op_i,
  input  hmmd_pkg::sts_t sts_i,
  output hmmd_pkg::cmd_t cmd_o
);
  import hmmd_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  op_e    op_q, op_d;
  logic   fresh_q, fresh_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_ALL;
      op_q    <= OP_NONE;
      fresh_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      op_q    <= op_d;
      fresh_q <= fresh_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    op_d          = op_q;
    fresh_d       = fresh_q;
    cmd_o         = '0;
    cmd_o.idx_op  = IDX_HOLD;
    cmd_o.src     = SRC_NONE;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          op_d         = op_i;
          state_d      = (op_i == OP_SNAP) ? ST_SNAP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          case (op_q)
            OP_PUSH: begin
              cmd_o.do_push = 1'b1;
              cmd_o.src     = SRC_PUSH;
            end
            OP_CLEAR: cmd_o.do_clear = 1'b1;
            default: ;
          endcase
          state_d = ST_IDLE;
        end
      end
      ST_SNAP: begin
        if (sts_i.lim_zero || sts_i.n_zero) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (sts_i.fits) begin
          cmd_o.idx_op = IDX_ZERO;
          phase_d      = PH_ALL;
          state_d      = ST_RD;
        end else if (sts_i.lim_one) begin
          cmd_o.idx_op = IDX_LAST;
          phase_d      = PH_LASTPT;
          state_d      = ST_RD;
        end else begin
          cmd_o.idx_op = IDX_ZERO;
          phase_d      = PH_FIRST;
          state_d      = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_DAT;
      end
      ST_DAT: begin
        case (phase_q)
          PH_ALL: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.src  = SRC_RD;
              cmd_o.last = sts_i.idx_is_last;
              if (sts_i.idx_is_last) begin
                state_d = ST_IDLE;
              end else begin
                cmd_o.idx_op = IDX_INC;
                state_d      = ST_RD;
              end
            end
          end
          PH_LASTPT: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.src  = SRC_RD;
              cmd_o.last = 1'b1;
              state_d    = ST_IDLE;
            end
          end
          PH_FIRST: begin
            if (sts_i.out_free) begin
              cmd_o.emit       = 1'b1;
              cmd_o.src        = SRC_RD;
              cmd_o.save_first = 1'b1;
              if (sts_i.lim_two) begin
                cmd_o.idx_op = IDX_LAST;
                phase_d      = PH_LASTPT;
                state_d      = ST_RD;
              end else if (sts_i.lim_three) begin
                cmd_o.idx_op = IDX_ONE;
                phase_d      = PH_SCAN3;
                fresh_d      = 1'b1;
                state_d      = ST_RD;
              end else begin
                cmd_o.div_start = 1'b1;
                state_d         = ST_DIV;
              end
            end
          end
          PH_SCAN3: begin
            cmd_o.scan_init = fresh_q;
            cmd_o.scan_upd  = !fresh_q;
            fresh_d         = 1'b0;
            if (sts_i.idx_is_nm2) begin
              cmd_o.idx_op = IDX_LAST;
              phase_d      = PH_LAST3;
            end else begin
              cmd_o.idx_op = IDX_INC;
            end
            state_d = ST_RD;
          end
          PH_SCANB: begin
            cmd_o.scan_init = fresh_q;
            cmd_o.scan_upd  = !fresh_q;
            fresh_d         = 1'b0;
            if (sts_i.idx_at_hi) begin
              state_d = ST_BEMIT1;
            end else begin
              cmd_o.idx_op = IDX_INC;
              state_d      = ST_RD;
            end
          end
          PH_LAST3: state_d = ST_C3;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.bkt_init = 1'b1;
          cmd_o.idx_op   = IDX_ONE;
          phase_d        = PH_SCANB;
          fresh_d        = 1'b1;
          state_d        = ST_RD;
        end
      end
      ST_C3: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = sts_i.pick_min ? SRC_MIN : SRC_MAX;
          phase_d    = PH_LASTPT;
          state_d    = ST_DAT;
        end
      end
      ST_BEMIT1: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.mn_eq_mx) begin
            cmd_o.src      = SRC_MIN;
            cmd_o.idx_op   = IDX_INC;
            cmd_o.bkt_next = 1'b1;
            fresh_d        = 1'b1;
            phase_d        = sts_i.bkt_last ? PH_LASTPT : PH_SCANB;
            state_d        = ST_RD;
          end else begin
            cmd_o.src = sts_i.mn_lt_mx ? SRC_MIN : SRC_MAX;
            state_d   = ST_BEMIT2;
          end
        end
      end
      ST_BEMIT2: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = sts_i.mn_lt_mx ? SRC_MAX : SRC_MIN;
          cmd_o.idx_op   = IDX_INC;
          cmd_o.bkt_next = 1'b1;
          fresh_d        = 1'b1;
          phase_d        = sts_i.bkt_last ? PH_LASTPT : PH_SCANB;
          state_d        = ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/hmmd_datapath.sv -----
// Datapath of the history min/max downsampler: history memory, scan, divider, output register.
module hmmd_datapath #(
  parameter int unsigned HISTORY_DEPTH   = 1024,
  parameter int unsigned MAX_PLOT_POINTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hmmd_pkg::LimitW-1:0]         cfg_wdata_i,
  input  logic [hmmd_pkg::TimeW-1:0]          sample_time_us_i,
  input  logic signed [hmmd_pkg::ValueW-1:0]  sample_value_i,
  input  logic [hmmd_pkg::MaxPtsW-1:0]        max_points_i,
  input  hmmd_pkg::cmd_t                       cmd_i,
  output hmmd_pkg::sts_t                       sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                accepted_o,
  output logic                                has_point_o,
  output logic [hmmd_pkg::TimeW-1:0]          point_time_us_o,
  output logic signed [hmmd_pkg::ValueW-1:0]  point_value_o,
  output logic                                last_o
);
  import hmmd_pkg::*;

  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned LW  = $clog2(MAX_PLOT_POINTS + 1);
  localparam int unsigned BW  = LW;
  localparam int unsigned DCW = $clog2(CW + 1);
  localparam logic [SW-1:0] DepthS = SW'(HISTORY_DEPTH);

  // History store; entries are read only after a push has written them.
  logic [TimeW-1:0]         mem_t [HISTORY_DEPTH];
  logic signed [ValueW-1:0] mem_v [HISTORY_DEPTH];

  logic [LimitW-1:0] limit_q;
  logic [AW-1:0]     oldest_q, oldest_d;
  logic [CW-1:0]     count_q, count_d;
  logic [TimeW-1:0]  newest_q, newest_d;
  logic              seen_q, seen_d;

  logic [TimeW-1:0]         t_q;
  logic signed [ValueW-1:0] v_q;
  logic [LW-1:0]            lim_q;

  logic [TimeW-1:0]         rd_t_q;
  logic signed [ValueW-1:0] rd_v_q;
  logic [CW-1:0]            idx_q, idx_d;

  logic [CW-1:0]            mn_idx_q, mx_idx_q;
  logic [TimeW-1:0]         mn_t_q, mx_t_q;
  logic signed [ValueW-1:0] mn_v_q, mx_v_q, first_v_q;

  logic [DCW-1:0] div_cnt_q;
  logic [CW-1:0]  quo_q;
  logic [BW-1:0]  rem_q;
  logic [CW-1:0]  acc_q;
  logic [BW-1:0]  accr_q;
  logic [BW-1:0]  bkt_q;

  logic                     out_valid_q;
  logic                     out_acc_q, out_has_q, out_last_q;
  logic [TimeW-1:0]         out_t_q;
  logic signed [ValueW-1:0] out_v_q;

  // Ring addressing.
  logic [SW-1:0] rd_sum, wr_sum;
  logic [AW-1:0] rd_addr, wr_addr;
  always_comb begin
    rd_sum  = SW'(oldest_q) + SW'(idx_q);
    wr_sum  = SW'(oldest_q) + SW'(count_q);
    rd_addr = (rd_sum >= DepthS) ? AW'(rd_sum - DepthS) : AW'(rd_sum);
    wr_addr = (wr_sum >= DepthS) ? AW'(wr_sum - DepthS) : AW'(wr_sum);
  end

  // Push and clear bookkeeping.
  logic          push_ok;
  logic [CW-1:0] elim;
  logic [SW-1:0] new_cnt, drop, osum;
  always_comb begin
    push_ok = !(seen_q && (t_q < newest_q));
    if (limit_q == '0) begin
      elim = CW'(1);
    end else if (32'(limit_q) > 32'(HISTORY_DEPTH)) begin
      elim = CW'(HISTORY_DEPTH);
    end else begin
      elim = CW'(limit_q);
    end
    new_cnt  = SW'(count_q) + SW'(1);
    drop     = new_cnt - SW'(elim);
    osum     = SW'(oldest_q) + drop;
    oldest_d = oldest_q;
    count_d  = count_q;
    newest_d = newest_q;
    seen_d   = seen_q;
    if (cmd_i.do_push && push_ok) begin
      if (new_cnt > SW'(elim)) begin
        oldest_d = (osum >= DepthS) ? AW'(osum - DepthS) : AW'(osum);
        count_d  = elim;
      end else begin
        count_d = CW'(new_cnt);
      end
      newest_d = t_q;
      seen_d   = 1'b1;
    end else if (cmd_i.do_clear) begin
      oldest_d = '0;
      count_d  = '0;
      newest_d = '0;
      seen_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitReset;
      oldest_q <= '0;
      count_q  <= '0;
      newest_q <= '0;
      seen_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      oldest_q <= oldest_d;
      count_q  <= count_d;
      newest_q <= newest_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push && push_ok) begin
      mem_t[wr_addr] <= t_q;
      mem_v[wr_addr] <= v_q;
    end
    if (cmd_i.rd_en) begin
      rd_t_q <= mem_t[rd_addr];
      rd_v_q <= mem_v[rd_addr];
    end
  end

  // Input latch and scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_q   <= sample_time_us_i;
      v_q   <= sample_value_i;
      lim_q <= (32'(max_points_i) > 32'(MAX_PLOT_POINTS)) ? LW'(MAX_PLOT_POINTS)
                                                          : LW'(max_points_i);
    end
    if (cmd_i.save_first) begin
      first_v_q <= rd_v_q;
    end
    if (cmd_i.scan_init) begin
      mn_idx_q <= idx_q;
      mn_t_q   <= rd_t_q;
      mn_v_q   <= rd_v_q;
      mx_idx_q <= idx_q;
      mx_t_q   <= rd_t_q;
      mx_v_q   <= rd_v_q;
    end else if (cmd_i.scan_upd) begin
      if (rd_v_q < mn_v_q) begin
        mn_idx_q <= idx_q;
        mn_t_q   <= rd_t_q;
        mn_v_q   <= rd_v_q;
      end
      if (rd_v_q > mx_v_q) begin
        mx_idx_q <= idx_q;
        mx_t_q   <= rd_t_q;
        mx_v_q   <= rd_v_q;
      end
    end
  end

  // Point index.
  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_ONE:  idx_d = CW'(1);
      IDX_INC:  idx_d = idx_q + CW'(1);
      IDX_LAST: idx_d = count_q - CW'(1);
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Bucket boundaries: interior / buckets by restoring division, then stepped sums.
  logic [BW-1:0] buckets;
  logic [BW:0]   trial, trial_sub;
  logic          trial_ge;
  logic [BW-1:0] rsum, rsum_sub;
  always_comb begin
    buckets   = BW'((32'(lim_q) - 32'd2) >> 1);
    trial     = {rem_q, quo_q[CW-1]};
    trial_ge  = trial >= {1'b0, buckets};
    trial_sub = trial - {1'b0, buckets};
    rsum      = accr_q + rem_q;
    rsum_sub  = rsum - buckets;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DCW'(CW);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= count_q - CW'(2);
      rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      quo_q <= {quo_q[CW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[BW-1:0] : trial[BW-1:0];
    end
    if (cmd_i.bkt_init) begin
      acc_q  <= quo_q;
      accr_q <= rem_q;
      bkt_q  <= '0;
    end else if (cmd_i.bkt_next) begin
      if (rsum >= buckets) begin
        acc_q  <= acc_q + quo_q + CW'(1);
        accr_q <= rsum_sub;
      end else begin
        acc_q  <= acc_q + quo_q;
        accr_q <= rsum;
      end
      bkt_q <= bkt_q + BW'(1);
    end
  end

  // Middle point choice for a three-point snapshot.
  logic signed [ValueW+2:0] mid_sum, dmin, dmax;
  logic [ValueW+2:0]        amin, amax;
  always_comb begin
    mid_sum = {{3{first_v_q[ValueW-1]}}, first_v_q} + {{3{rd_v_q[ValueW-1]}}, rd_v_q};
    dmin    = {{2{mn_v_q[ValueW-1]}}, mn_v_q, 1'b0} - mid_sum;
    dmax    = {{2{mx_v_q[ValueW-1]}}, mx_v_q, 1'b0} - mid_sum;
    amin    = dmin[ValueW+2] ? $unsigned(-dmin) : $unsigned(dmin);
    amax    = dmax[ValueW+2] ? $unsigned(-dmax) : $unsigned(dmax);
  end

  always_comb begin
    sts_o.n_zero      = (count_q == '0);
    sts_o.lim_zero    = (lim_q == '0);
    sts_o.fits        = (32'(count_q) <= 32'(lim_q));
    sts_o.lim_one     = (32'(lim_q) == 32'd1);
    sts_o.lim_two     = (32'(lim_q) == 32'd2);
    sts_o.lim_three   = (32'(lim_q) == 32'd3);
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.idx_is_last = (idx_q == count_q - CW'(1));
    sts_o.idx_is_nm2  = (idx_q == count_q - CW'(2));
    sts_o.idx_at_hi   = (idx_q == acc_q);
    sts_o.div_done    = (div_cnt_q == '0);
    sts_o.bkt_last    = (bkt_q == buckets - BW'(1));
    sts_o.mn_eq_mx    = (mn_idx_q == mx_idx_q);
    sts_o.mn_lt_mx    = (mn_idx_q < mx_idx_q);
    sts_o.pick_min    = (amin >= amax);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.last;
      case (cmd_i.src)
        SRC_PUSH: begin
          out_acc_q <= push_ok;
          out_has_q <= 1'b0;
          out_t_q   <= '0;
          out_v_q   <= '0;
        end
        SRC_RD: begin
          out_acc_q <= 1'b0;
          out_has_q <= 1'b1;
          out_t_q   <= rd_t_q;
          out_v_q   <= rd_v_q;
        end
        SRC_MIN: begin
          out_acc_q <= 1'b0;
          out_has_q <= 1'b1;
          out_t_q   <= mn_t_q;
          out_v_q   <= mn_v_q;
        end
        SRC_MAX: begin
          out_acc_q <= 1'b0;
          out_has_q <= 1'b1;
          out_t_q   <= mx_t_q;
          out_v_q   <= mx_v_q;
        end
        default: begin
          out_acc_q <= 1'b0;
          out_has_q <= 1'b0;
          out_t_q   <= '0;
          out_v_q   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign has_point_o     = out_has_q;
  assign point_time_us_o = out_t_q;
  assign point_value_o   = out_v_q;
  assign last_o          = out_last_q;

endmodule

// ----- hdl/hmmd_checker.sv -----
// Port-level checks of the history min/max downsampler and their bind.
module hmmd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                accepted_o,
  input logic                                has_point_o,
  input logic [hmmd_pkg::TimeW-1:0]          point_time_us_o,
  input logic signed [hmmd_pkg::ValueW-1:0]  point_value_o,
  input logic                                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({accepted_o, has_point_o, point_time_us_o, point_value_o, last_o}))
    else $error("output beat changed while stalled");

  a_no_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_point_o |-> point_time_us_o == '0 && point_value_o == '0)
    else $error("beat without a point carries data");

  a_accept_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !has_point_o && last_o)
    else $error("accepted push beat is not a single final beat");

  a_point_not_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_point_o |-> !accepted_o)
    else $error("snapshot point flagged as accepted push");

endmodule

bind history_minmax_downsampler hmmd_checker u_hmmd_checker (.*);

// ----- tb/sv/tb_history_minmax_downsampler.sv -----
// Testbench for the history min/max downsampler: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module tb_history_minmax_downsampler;
  import hmmd_pkg::*;

  localparam int unsigned Depth   = 1024;
  localparam int unsigned MaxPlot = 64;

  // One result beat as the block should produce it.
  typedef struct packed {
    logic              accepted;
    logic              has_point;
    logic [TimeW-1:0]  pt_time;
    logic [ValueW-1:0] pt_value;
    logic              last;
  } point_beat_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [LimitW-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OpW-1:0]           operation_i;
  logic [TimeW-1:0]         sample_time_us_i;
  logic signed [ValueW-1:0] sample_value_i;
  logic [MaxPtsW-1:0]       max_points_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     accepted_o;
  logic                     has_point_o;
  logic [TimeW-1:0]         point_time_us_o;
  logic signed [ValueW-1:0] point_value_o;
  logic                     last_o;

  history_minmax_downsampler #(
    .HISTORY_DEPTH  (Depth),
    .MAX_PLOT_POINTS(MaxPlot)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .sample_time_us_i(sample_time_us_i),
    .sample_value_i  (sample_value_i),
    .max_points_i    (max_points_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .has_point_o     (has_point_o),
    .point_time_us_o (point_time_us_o),
    .point_value_o   (point_value_o),
    .last_o          (last_o)
  );

  // Predictor state: a mirror of the ring store and its bookkeeping.
  logic [TimeW-1:0]        ring_time [Depth];
  logic signed [ValueW-1:0] ring_value [Depth];
  int unsigned             ring_head;
  int unsigned             ring_count;
  logic [TimeW-1:0]        newest_stamp;
  bit                      stamp_seen;
  int unsigned             limit_reg;

  point_beat_t expected_beats[$];
  int unsigned mismatch_count;
  int unsigned stray_count;

  // Percent chances of idling on each side; the initial block changes them per phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Timestamp cursor for well-formed push sequences.
  logic [TimeW-1:0] stamp_cursor;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #80ms;
    $display("** history_minmax_downsampler: FAILED **");
    $finish;
  end

  function automatic logic signed [ValueW-1:0] value_at(int unsigned idx);
    return ring_value[(ring_head + idx) % Depth];
  endfunction

  function automatic void queue_point(int unsigned idx);
    point_beat_t b;
    int unsigned slot;
    slot = (ring_head + idx) % Depth;
    b = '{accepted: 1'b0, has_point: 1'b1, pt_time: ring_time[slot],
          pt_value: ring_value[slot], last: 1'b0};
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic void queue_plain(logic acc);
    point_beat_t b;
    b = '{accepted: acc, has_point: 1'b0, pt_time: '0, pt_value: '0, last: 1'b1};
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // Decimation of the stored history to at most the requested number of points.
  function automatic void predict_snapshot(int unsigned req);
    int unsigned lim, n, mn, mx, lo, hi, nb;
    longint sum, dmin, dmax;
    longint unsigned inner;
    lim = (req > MaxPlot) ? MaxPlot : req;
    n = ring_count;
    if (lim == 0 || n == 0) begin
      queue_plain(1'b0);
      return;
    end
    if (n <= lim) begin
      for (int unsigned i = 0; i < n; i++) queue_point(i);
    end else if (lim == 1) begin
      queue_point(n - 1);
    end else begin
      queue_point(0);
      if (lim == 3) begin
        mn = 1;
        mx = 1;
        for (int unsigned i = 1; i + 1 < n; i++) begin
          if (value_at(i) < value_at(mn)) mn = i;
          if (value_at(i) > value_at(mx)) mx = i;
        end
        sum = longint'(value_at(0)) + longint'(value_at(n - 1));
        dmin = 2 * longint'(value_at(mn)) - sum;
        dmax = 2 * longint'(value_at(mx)) - sum;
        if (dmin < 0) dmin = -dmin;
        if (dmax < 0) dmax = -dmax;
        queue_point((dmin >= dmax) ? mn : mx);
      end else if (lim >= 4) begin
        inner = n - 2;
        nb = (lim - 2) / 2;
        for (int unsigned b = 0; b < nb; b++) begin
          lo = 1 + int'(inner * b / nb);
          hi = 1 + int'(inner * (b + 1) / nb);
          mn = lo;
          mx = lo;
          for (int unsigned i = lo + 1; i < hi; i++) begin
            if (value_at(i) < value_at(mn)) mn = i;
            if (value_at(i) > value_at(mx)) mx = i;
          end
          if (mn == mx) begin
            queue_point(mn);
          end else if (mn < mx) begin
            queue_point(mn);
            queue_point(mx);
          end else begin
            queue_point(mx);
            queue_point(mn);
          end
        end
      end
      queue_point(n - 1);
    end
    expected_beats[$].last = 1'b1;
  endfunction

  function automatic void predict_item(op_e op, logic [TimeW-1:0] t,
                                       logic signed [ValueW-1:0] v, int unsigned req);
    int unsigned eff;
    case (op)
      OP_PUSH: begin
        if (stamp_seen && t < newest_stamp) begin
          queue_plain(1'b0);
        end else begin
          ring_time[(ring_head + ring_count) % Depth] = t;
          ring_value[(ring_head + ring_count) % Depth] = v;
          ring_count++;
          eff = (limit_reg < 1) ? 1 : ((limit_reg > Depth) ? Depth : limit_reg);
          if (ring_count > eff) begin
            ring_head = (ring_head + ring_count - eff) % Depth;
            ring_count = eff;
          end
          newest_stamp = t;
          stamp_seen = 1'b1;
          queue_plain(1'b1);
        end
      end
      OP_SNAP: predict_snapshot(req);
      OP_CLEAR: begin
        ring_head = 0;
        ring_count = 0;
        newest_stamp = '0;
        stamp_seen = 1'b0;
        queue_plain(1'b0);
      end
      default: queue_plain(1'b0);
    endcase
  endfunction

  // Sends one item: after the previous beat and an optional idle gap, valid is raised
  // and held until the beat is taken.
  task automatic send_item(op_e op, logic [TimeW-1:0] t, logic signed [ValueW-1:0] v,
                           logic [MaxPtsW-1:0] req);
    do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    sample_time_us_i <= t;
    sample_value_i   <= v;
    max_points_i     <= req;
    predict_item(op, t, v, req);
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
  endtask

  // Waits for the block to drain, then writes the history limit.
  task automatic write_limit(int unsigned value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[LimitW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_reg = value;
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(7) - 3;
      default: return $urandom();
    endcase
  endfunction

  // Mostly in-order pushes; sometimes a random timestamp to exercise rejection.
  task automatic push_random();
    logic [TimeW-1:0] t;
    if ($urandom_range(9) == 0) begin
      t = TimeW'({$urandom(), $urandom()});
    end else begin
      stamp_cursor = stamp_cursor + $urandom_range(3);
      t = stamp_cursor;
    end
    send_item(OP_PUSH, t, rand_value(), '0);
  endtask

  // Output side: random stalls and the field-by-field comparison.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= 10)
            $display("unexpected result beat at %0t", $realtime);
        end else begin
          point_beat_t want;
          want = expected_beats[0];
          expected_beats.delete(0);
          if (want.accepted !== accepted_o || want.has_point !== has_point_o ||
              want.pt_time !== point_time_us_o || want.pt_value !== point_value_o ||
              want.last !== last_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at %0t: expected acc %0b pt %0b t %0h v %0h last %0b,",
                       $realtime, want.accepted, want.has_point, want.pt_time,
                       want.pt_value, want.last,
                       " got acc %0b pt %0b t %0h v %0h last %0b", accepted_o,
                       has_point_o, point_time_us_o, point_value_o, last_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Field extremes, every operation, and the special snapshot shapes.
  task automatic test_directed();
    send_item(OP_SNAP, '0, '0, 7'd5);            // empty history
    send_item(OP_PUSH, '0, 32'sh80000000, '0);
    send_item(OP_PUSH, 48'd10, 32'sh7fffffff, '0);
    send_item(OP_PUSH, 48'd5, 32'sd1, '0);       // older stamp is rejected
    send_item(OP_PUSH, 48'd10, 32'sd0, '0);      // equal stamp is taken
    send_item(OP_PUSH, 48'd20, -32'sd7, '0);
    send_item(OP_SNAP, '0, '0, 7'd0);            // zero points requested
    send_item(OP_SNAP, '0, '0, 7'd1);
    send_item(OP_SNAP, '0, '0, 7'd2);
    send_item(OP_SNAP, '0, '0, 7'd3);
    send_item(OP_SNAP, '0, '0, 7'd4);
    send_item(OP_SNAP, '0, '0, 7'd127);          // saturates
    send_item(OP_NONE, '1, '1, '1);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_PUSH, 48'd3, 32'sd2, '0);       // stamp forgotten after clear
    send_item(OP_PUSH, '1, 32'sd2, '0);          // ties in value
    send_item(OP_PUSH, '1, 32'sd2, '0);
    send_item(OP_SNAP, '0, '0, 7'd3);
    send_item(OP_SNAP, '0, '0, 7'h40);
    send_item(OP_CLEAR, '0, '0, '0);
  endtask

  // Random mixes of pushes, snapshots, clears and unknown ops across limits and idling patterns.
  task automatic test_random(int unsigned count, int unsigned limit);
    int unsigned sel;
    write_limit(limit);
    stamp_cursor = '0;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 70) push_random();
      else if (sel < 92) send_item(OP_SNAP, '0, '0, MaxPtsW'($urandom()));
      else if (sel < 96) send_item(OP_CLEAR, '0, '0, '0);
      else send_item(OP_NONE, TimeW'({$urandom(), $urandom()}), ValueW'($urandom()),
                     MaxPtsW'($urandom()));
      if (sel >= 92 && sel < 96) stamp_cursor = '0;
    end
  endtask

  // Lowering the limit below the stored count trims on the next push.
  task automatic test_limit_shrink();
    write_limit(40);
    for (int unsigned i = 0; i < 30; i++) push_random();
    write_limit(6);
    push_random();
    send_item(OP_SNAP, '0, '0, 7'd64);
    write_limit(0);                              // clamps to one
    push_random();
    send_item(OP_SNAP, '0, '0, 7'd64);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    operation_i      = OP_PUSH;
    sample_time_us_i = '0;
    sample_value_i   = '0;
    max_points_i     = '0;
    out_ready_i      = 1'b0;
    ring_head        = 0;
    ring_count       = 0;
    newest_stamp     = '0;
    stamp_seen       = 1'b0;
    limit_reg        = LimitReset;
    mismatch_count   = 0;
    stray_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    stamp_cursor     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(100, 20);
    send_idle_pct = 57; recv_stall_pct = 0;  test_random(90, 1);
    send_idle_pct = 0;  recv_stall_pct = 57; test_random(90, 2047);
    send_idle_pct = 14; recv_stall_pct = 14; test_random(90, 9);
    test_limit_shrink();
    write_limit(1024);

    wait_drained();
    if (mismatch_count == 0 && stray_count == 0) begin
      $display("** history_minmax_downsampler: PASSED **");
    end else begin
      $display("** history_minmax_downsampler: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/hmmd_pkg.sv
hdl/hmmd_ctrl.sv
hdl/hmmd_datapath.sv
hdl/history_minmax_downsampler.sv
hdl/hmmd_checker.sv
tb/sv/tb_history_minmax_downsampler.sv
